FILE: src/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the grid ray caster
// Field structs, status and operation codes, fixed-point formats, widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

   // Map and fixed-point formats
   localparam int MAP_BITS   = 6;
   localparam int MAP_SIZE   = 1 << MAP_BITS;
   localparam int MAP_DEPTH  = MAP_SIZE * MAP_SIZE;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_STEPS  = 128;
   localparam int STEP_W     = $clog2(MAX_STEPS + 1);
   localparam int DIST_W     = 8 + FRAC_BITS;
   localparam int RAY_W      = 33;
   localparam int CAM_W      = 30;
   localparam int DIV_W      = 40;
   localparam int DEN_W      = 33;
   localparam int CELL_W     = MAP_BITS + 2;

   localparam logic [DIST_W-1:0] DMAX      = {DIST_W{1'b1}};
   localparam logic [7:0]        WALL_CODE = 8'd49;
   localparam logic [15:0]       LH_MAX    = 16'hFFFF;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 22;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd7;

   // Operation codes
   localparam logic OP_MAP_WRITE = 1'b0;
   localparam logic OP_CAST      = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_HIT     = 2'd0;
   localparam logic [1:0] STATUS_WRITTEN = 2'd1;
   localparam logic [1:0] STATUS_NO_WALL = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [10:0] column;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic [7:0]  cell_value;
   } req_type;

   typedef struct packed {
      logic [10:0] column_out;
      logic [1:0]  status;
      logic        hit_side;
      logic [5:0]  hit_cell_x;
      logic [5:0]  hit_cell_y;
      logic [15:0] line_height;
      logic [10:0] draw_start;
      logic [10:0] draw_end;
      logic [7:0]  texture_index;
      logic [15:0] wall_fraction;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/rcc_ram.sv
// ----------------------------------------------------------------------------
// rcc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/rcc_divider.sv
// ----------------------------------------------------------------------------
// rcc_divider: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_divider
   import rcc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [DIV_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] trial;

   // One restoring step
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = {1'b0, shifted} - {2'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ~trial[DEN_W+1]};
         rem_in = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

   // Assertions
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != '0) |-> rem_ff < den_ff) else $error("remainder overflow");

endmodule

`default_nettype wire

FILE: src/grid_ray_caster_column_top.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_column_top: DDA grid ray caster for one screen column
// Map writes load a 64x64 byte cell map; cast items march a ray to a wall.
// ----------------------------------------------------------------------------
// A map-write item stores one cell and returns its result in the cycle after it is taken.
// A cast item works through one shared divider five times (camera x, two
// reciprocals of the ray, perpendicular distance, line height; zero ray
// components skip their divide) and marches the map cell by cell, one step
// state and one read of the map RAM per cell, at most MAX_STEPS cells.
// One item is in work at a time; a result that waits in the result register
// holds off the next item.
`default_nettype none

module grid_ray_caster_column_top
   import rcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CAM_WAIT, ST_RAY, ST_DELTA, ST_DELTA_WAIT, ST_SIDE, ST_STEP,
      ST_READ, ST_PERP, ST_PERP_WAIT, ST_LH, ST_LH_WAIT, ST_FINISH, ST_NOWALL
   } state_type;

   // Configuration registers
   logic        [21:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic        [11:0] width_ff, height_ff;

   // Control and datapath registers
   state_type                 state_ff, state_in;
   logic                      axis_ff, axis_in;
   logic                      hs_ff, hs_in;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic [10:0]               col_ff, col_in;
   logic signed [CAM_W-1:0]   cam_ff, cam_in;
   logic signed [RAY_W-1:0]   ray_ff [2];
   logic signed [RAY_W-1:0]   ray_in [2];
   logic [DIST_W-1:0]         delta_ff [2];
   logic [DIST_W-1:0]         delta_in [2];
   logic [DIST_W-1:0]         side_ff [2];
   logic [DIST_W-1:0]         side_in [2];
   logic signed [CELL_W-1:0]  cell_ff [2];
   logic signed [CELL_W-1:0]  cell_in [2];
   logic [DIST_W-1:0]         perp_ff, perp_in;
   logic [15:0]               lh_ff, lh_in;
   logic                      div_start_ff, div_start_in;
   logic [DIV_W-1:0]          div_num_ff, div_num_in;
   logic [DEN_W-1:0]          div_den_ff, div_den_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [7:0]       map_rd_data;
   logic             req_accept, out_free, map_wr_en;

   assign csr_ready = 1'b1;

   // Hold configuration; the user must write only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= 18'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 18'sd43254;
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POS_X:   pos_x_ff   <= csr_wdata;
            CSR_POS_Y:   pos_y_ff   <= csr_wdata;
            CSR_DIR_X:   dir_x_ff   <= csr_wdata[17:0];
            CSR_DIR_Y:   dir_y_ff   <= csr_wdata[17:0];
            CSR_PLANE_X: plane_x_ff <= csr_wdata[17:0];
            CSR_PLANE_Y: plane_y_ff <= csr_wdata[17:0];
            CSR_WIDTH:   width_ff   <= csr_wdata[11:0];
            CSR_HEIGHT:  height_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign map_wr_en  = req_accept && (req_data.operation == OP_MAP_WRITE);

   // Camera ray for the current axis
   logic signed [17:0]      plane_sel, dir_sel;
   logic signed [47:0]      ray_prod;
   logic signed [RAY_W-1:0] ray_new;
   logic [RAY_W-1:0]        ray_mag [2];

   assign plane_sel = axis_ff ? plane_y_ff : plane_x_ff;
   assign dir_sel   = axis_ff ? dir_y_ff : dir_x_ff;
   assign ray_prod  = 48'(plane_sel) * 48'(cam_ff);
   assign ray_new   = RAY_W'(dir_sel) + RAY_W'(ray_prod >>> FRAC_BITS);
   assign ray_mag[0] = ray_ff[0][RAY_W-1] ? RAY_W'(-ray_ff[0]) : RAY_W'(ray_ff[0]);
   assign ray_mag[1] = ray_ff[1][RAY_W-1] ? RAY_W'(-ray_ff[1]) : RAY_W'(ray_ff[1]);

   // First side distance for the current axis
   logic [FRAC_BITS-1:0]   frac_sel;
   logic [FRAC_BITS:0]     side_mult;
   logic [FRAC_BITS+DIST_W:0] side_prod;
   logic [DIST_W:0]        side_raw;
   logic [DIST_W-1:0]      side_first;

   assign frac_sel  = axis_ff ? pos_y_ff[FRAC_BITS-1:0] : pos_x_ff[FRAC_BITS-1:0];
   assign side_mult = ray_ff[axis_ff][RAY_W-1] ? {1'b0, frac_sel}
                    : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac_sel};
   assign side_prod = side_mult * delta_ff[axis_ff];
   assign side_raw  = side_prod[FRAC_BITS+DIST_W:FRAC_BITS];
   assign side_first = (side_raw > {1'b0, DMAX}) ? DMAX : side_raw[DIST_W-1:0];

   // One march step
   logic                     hs_sel;
   logic [DIST_W:0]          side_sum;
   logic signed [CELL_W-1:0] cell_next;
   logic                     cell_off;
   logic [2*MAP_BITS-1:0]    map_rd_addr;

   assign hs_sel    = (side_ff[0] < side_ff[1]) ? 1'b0 : 1'b1;
   assign side_sum  = {1'b0, side_ff[hs_sel]} + {1'b0, delta_ff[hs_sel]};
   assign cell_next = ray_ff[hs_sel][RAY_W-1] ? cell_ff[hs_sel] - CELL_W'(1)
                                              : cell_ff[hs_sel] + CELL_W'(1);
   assign cell_off  = cell_next[CELL_W-1:MAP_BITS] != '0;
   assign map_rd_addr = hs_sel ? {cell_ff[0][MAP_BITS-1:0], cell_next[MAP_BITS-1:0]}
                               : {cell_next[MAP_BITS-1:0], cell_ff[1][MAP_BITS-1:0]};

   // Distance from the viewer to the crossed boundary on the hit axis
   logic [21:0]        pos_hs;
   logic signed [25:0] bound;
   logic [23:0]        bound_mag;

   assign pos_hs    = hs_ff ? pos_y_ff : pos_x_ff;
   assign bound     = (26'(cell_ff[hs_ff]) <<< FRAC_BITS) - $signed({4'b0, pos_hs})
                    + (ray_ff[hs_ff][RAY_W-1] ? 26'sd65536 : 26'sd0);
   assign bound_mag = bound[25] ? 24'(-bound) : 24'(bound);

   // Wall fraction along the other axis
   logic [21:0]        pos_other;
   logic [55:0]        wall_prod;
   logic [15:0]        wall_frac;

   assign pos_other = hs_ff ? pos_x_ff : pos_y_ff;
   assign wall_prod = perp_ff * ray_ff[~hs_ff][31:0];
   assign wall_frac = pos_other[15:0] + wall_prod[31:16];

   // Slice rows
   logic [11:0]        half_h;
   logic [14:0]        half_lh;
   logic signed [16:0] ds_raw;
   logic [16:0]        de_raw, de_lim;
   logic [10:0]        draw_start, draw_end;

   assign half_h  = {1'b0, height_ff[11:1]};
   assign half_lh = lh_ff[15:1];
   assign ds_raw  = $signed({5'b0, half_h}) - $signed({2'b0, half_lh});
   assign draw_start = ds_raw[16] ? 11'd0
                     : (ds_raw > 17'sd2047 ? 11'd2047 : ds_raw[10:0]);
   assign de_raw  = 17'(half_h) + 17'(half_lh);
   assign de_lim  = (height_ff == '0) ? 17'd0
                  : (de_raw >= 17'(height_ff) ? 17'(height_ff - 12'd1) : de_raw);
   assign draw_end = (de_lim > 17'd2047) ? 11'd2047 : de_lim[10:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      hs_in        = hs_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      cam_in       = cam_ff;
      ray_in       = ray_ff;
      delta_in     = delta_ff;
      side_in      = side_ff;
      cell_in      = cell_ff;
      perp_in      = perp_ff;
      lh_in        = lh_ff;
      div_start_in = 1'b0;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               col_in = req_data.column;
               if (req_data.operation == OP_MAP_WRITE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in.column_out = req_data.column;
                  rsp_data_in.status     = STATUS_WRITTEN;
               end else begin
                  div_start_in = 1'b1;
                  div_num_in   = DIV_W'({req_data.column, 1'b0}) << FRAC_BITS;
                  div_den_in   = DEN_W'((width_ff == '0) ? 12'd1 : width_ff);
                  state_in     = ST_CAM_WAIT;
               end
            end
         end
         ST_CAM_WAIT: begin
            if (div_done) begin
               cam_in   = $signed({2'b0, div_quo[27:0]}) - CAM_W'(1 << FRAC_BITS);
               axis_in  = 1'b0;
               state_in = ST_RAY;
            end
         end
         ST_RAY: begin
            ray_in[axis_ff] = ray_new;
            axis_in = ~axis_ff;
            if (axis_ff) begin
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            if (ray_ff[axis_ff] == '0) begin
               delta_in[axis_ff] = DMAX;
               axis_in = ~axis_ff;
               state_in = axis_ff ? ST_SIDE : ST_DELTA;
            end else begin
               div_start_in = 1'b1;
               div_num_in   = DIV_W'(1) << (2 * FRAC_BITS);
               div_den_in   = ray_mag[axis_ff];
               state_in     = ST_DELTA_WAIT;
            end
         end
         ST_DELTA_WAIT: begin
            if (div_done) begin
               delta_in[axis_ff] = (div_quo > DIV_W'(DMAX)) ? DMAX : div_quo[DIST_W-1:0];
               axis_in  = ~axis_ff;
               state_in = axis_ff ? ST_SIDE : ST_DELTA;
            end
         end
         ST_SIDE: begin
            side_in[axis_ff] = side_first;
            cell_in[axis_ff] = CELL_W'(axis_ff ? pos_y_ff[21:FRAC_BITS]
                                               : pos_x_ff[21:FRAC_BITS]);
            axis_in = ~axis_ff;
            cnt_in  = '0;
            if (axis_ff) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            hs_in = hs_sel;
            side_in[hs_sel] = side_sum[DIST_W] ? DMAX : side_sum[DIST_W-1:0];
            cell_in[hs_sel] = cell_next;
            cnt_in   = cnt_ff + 1'b1;
            state_in = cell_off ? ST_NOWALL : ST_READ;
         end
         ST_READ: begin
            if (map_rd_data == WALL_CODE) begin
               state_in = ST_PERP;
            end else if (cnt_ff == STEP_W'(MAX_STEPS)) begin
               state_in = ST_NOWALL;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_PERP: begin
            if (ray_ff[hs_ff] == '0) begin
               perp_in  = DMAX;
               state_in = ST_LH;
            end else begin
               div_start_in = 1'b1;
               div_num_in   = DIV_W'(bound_mag) << FRAC_BITS;
               div_den_in   = ray_mag[hs_ff];
               state_in     = ST_PERP_WAIT;
            end
         end
         ST_PERP_WAIT: begin
            if (div_done) begin
               perp_in  = (div_quo > DIV_W'(DMAX)) ? DMAX : div_quo[DIST_W-1:0];
               state_in = ST_LH;
            end
         end
         ST_LH: begin
            if (perp_ff == '0) begin
               lh_in    = LH_MAX;
               state_in = ST_FINISH;
            end else begin
               div_start_in = 1'b1;
               div_num_in   = DIV_W'(height_ff) << FRAC_BITS;
               div_den_in   = DEN_W'(perp_ff);
               state_in     = ST_LH_WAIT;
            end
         end
         ST_LH_WAIT: begin
            if (div_done) begin
               lh_in    = (div_quo > DIV_W'(LH_MAX)) ? LH_MAX : div_quo[15:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.column_out    = col_ff;
               rsp_data_in.status        = STATUS_HIT;
               rsp_data_in.hit_side      = hs_ff;
               rsp_data_in.hit_cell_x    = cell_ff[0][MAP_BITS-1:0];
               rsp_data_in.hit_cell_y    = cell_ff[1][MAP_BITS-1:0];
               rsp_data_in.line_height   = lh_ff;
               rsp_data_in.draw_start    = draw_start;
               rsp_data_in.draw_end      = draw_end;
               rsp_data_in.texture_index = WALL_CODE - 8'd1;
               rsp_data_in.wall_fraction = wall_frac;
               state_in = ST_IDLE;
            end
         end
         ST_NOWALL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.column_out = col_ff;
               rsp_data_in.status     = STATUS_NO_WALL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      axis_ff     <= axis_in;
      hs_ff       <= hs_in;
      col_ff      <= col_in;
      cam_ff      <= cam_in;
      ray_ff      <= ray_in;
      delta_ff    <= delta_in;
      side_ff     <= side_in;
      cell_ff     <= cell_in;
      perp_ff     <= perp_in;
      lh_ff       <= lh_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Cell map
   rcc_ram #(
      .WIDTH (8),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr ({req_data.cell_x, req_data.cell_y}),
      .wr_data (req_data.cell_value),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Shared divider
   rcc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Assertions
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE) else $error("item taken while busy");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= STEP_W'(MAX_STEPS) || state_ff == ST_IDLE)
      else $error("march ran past step limit");
   a_no_div_zero: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> div_den_ff != '0) else $error("divide by zero issued");
   a_result_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("hit result not delivered");

endmodule

`default_nettype wire

FILE: test/grid_ray_caster_column_top_tb.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_column_top_tb: self-checking bench of the column ray caster
// Writes each map cell before the first cast that reads it, runs a directed
// table, then phases of map writes and column casts under extreme and random
// camera settings. Every result is compared with a fixed-point DDA predictor
// kept inside this bench or, for fixed table rows, with the row's result.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_caster_column_top_tb;
   import rcc_pkg::*;

   localparam longint ONE       = longint'(1) << FRAC_BITS;
   localparam longint DIST_MAX  = (longint'(1) << (8 + FRAC_BITS)) - 1;
   localparam int     STALL_CAP = 5000;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } table_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Camera settings and cell map as the bench believes them
   logic [21:0]        cam_pos_x, cam_pos_y;
   logic signed [17:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
   logic [11:0]        scr_width, scr_height;
   logic [7:0]         cell_map [MAP_DEPTH];
   bit                 cell_known [MAP_DEPTH];

   rsp_type       pending_rsp [$];
   table_row_type directed [$];
   int            mismatches = 0;
   int            req_count = 0;
   int            csr_count = 0;
   int            stalled_cycles, stall_left;
   bit            quiet;
   bit            use_fixed;
   rsp_type       fixed_rsp;

   grid_ray_caster_column_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Expected result of one item; map writes also update the bench map.
   // A cast that would read a never-written cell stops there and names it.
   function automatic rsp_type cast_column(input req_type r, output int unknown);
      rsp_type res;
      longint  w, h, cam, perp, lh, half, ds, de, wall, bound, f, idx;
      longint  pos [2], ray [2], delta [2], side [2], step [2], grid [2];
      int      hs, n;
      bit      hit;
      unknown = -1;
      res = '0;
      res.column_out = r.column;
      if (r.operation == OP_MAP_WRITE) begin
         cell_map[{r.cell_x, r.cell_y}] = r.cell_value;
         cell_known[{r.cell_x, r.cell_y}] = 1'b1;
         res.status = STATUS_WRITTEN;
         return res;
      end
      res.status = STATUS_NO_WALL;
      w = (scr_width == 0) ? 1 : longint'(scr_width);
      h = longint'(scr_height);
      cam = ((longint'(r.column) * 2) << FRAC_BITS) / w - ONE;
      pos[0] = longint'(cam_pos_x);
      pos[1] = longint'(cam_pos_y);
      ray[0] = longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> FRAC_BITS);
      ray[1] = longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> FRAC_BITS);
      for (int k = 0; k < 2; k++) begin
         f = pos[k] & (ONE - 1);
         grid[k] = pos[k] >> FRAC_BITS;
         if (ray[k] == 0) delta[k] = DIST_MAX;
         else begin
            delta[k] = (longint'(1) << (2 * FRAC_BITS)) / (ray[k] < 0 ? -ray[k] : ray[k]);
            if (delta[k] > DIST_MAX) delta[k] = DIST_MAX;
         end
         if (ray[k] < 0) begin
            step[k] = -1;
            side[k] = (f * delta[k]) >> FRAC_BITS;
         end else begin
            step[k] = 1;
            side[k] = ((ONE - f) * delta[k]) >> FRAC_BITS;
         end
         if (side[k] > DIST_MAX) side[k] = DIST_MAX;
      end
      if (grid[0] >= MAP_SIZE || grid[1] >= MAP_SIZE) return res;
      // March the grid one cell per step
      hit = 1'b0;
      hs = 0;
      for (n = 0; n < MAX_STEPS && !hit; n++) begin
         hs = (side[0] < side[1]) ? 0 : 1;
         side[hs] = side[hs] + delta[hs];
         if (side[hs] > DIST_MAX) side[hs] = DIST_MAX;
         grid[hs] = grid[hs] + step[hs];
         if (grid[hs] < 0 || grid[hs] >= MAP_SIZE) return res;
         idx = grid[0] * MAP_SIZE + grid[1];
         if (!cell_known[idx]) begin
            unknown = int'(idx);
            return res;
         end
         if (cell_map[idx] == WALL_CODE) hit = 1'b1;
      end
      if (!hit) return res;
      bound = (grid[hs] << FRAC_BITS) - pos[hs] + (step[hs] < 0 ? ONE : 0);
      if (ray[hs] == 0) perp = DIST_MAX;
      else begin
         perp = ((bound < 0 ? -bound : bound) << FRAC_BITS)
                / (ray[hs] < 0 ? -ray[hs] : ray[hs]);
         if (perp > DIST_MAX) perp = DIST_MAX;
      end
      lh = (perp == 0) ? 65535 : (h << FRAC_BITS) / perp;
      if (lh > 65535) lh = 65535;
      half = lh / 2;
      ds = h / 2 - half;
      if (ds < 0) ds = 0;
      de = h / 2 + half;
      if (de >= h) de = h - 1;
      if (de < 0) de = 0;
      if (ds > 2047) ds = 2047;
      if (de > 2047) de = 2047;
      wall = pos[1-hs] + ((perp * ray[1-hs]) >>> FRAC_BITS);
      res.status        = STATUS_HIT;
      res.hit_side      = hs[0];
      res.hit_cell_x    = grid[0][5:0];
      res.hit_cell_y    = grid[1][5:0];
      res.line_height   = lh[15:0];
      res.draw_start    = ds[10:0];
      res.draw_end      = de[10:0];
      res.texture_index = cell_map[grid[0] * MAP_SIZE + grid[1]] - 8'd1;
      res.wall_fraction = wall[15:0];
      return res;
   endfunction

   function automatic rsp_type written_rsp(input logic [10:0] col);
      rsp_type res;
      res = '0;
      res.column_out = col;
      res.status = STATUS_WRITTEN;
      return res;
   endfunction

   // Predict on every accepted item transfer
   always @(posedge clock) begin
      rsp_type p;
      int      unk;
      if (!reset && req_valid && !req_stall) begin
         p = cast_column(req_data, unk);
         pending_rsp.push_back(use_fixed ? fixed_rsp : p);
         req_count <= req_count + 1;
      end
      if (!reset && csr_valid && csr_ready) csr_count <= csr_count + 1;
   end

   // Check every result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      string   bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            bad = "";
            if (rsp_data.column_out !== e.column_out) bad = {bad, " column_out"};
            if (rsp_data.status !== e.status) bad = {bad, " status"};
            if (rsp_data.hit_side !== e.hit_side) bad = {bad, " hit_side"};
            if (rsp_data.hit_cell_x !== e.hit_cell_x) bad = {bad, " hit_cell_x"};
            if (rsp_data.hit_cell_y !== e.hit_cell_y) bad = {bad, " hit_cell_y"};
            if (rsp_data.line_height !== e.line_height) bad = {bad, " line_height"};
            if (rsp_data.draw_start !== e.draw_start) bad = {bad, " draw_start"};
            if (rsp_data.draw_end !== e.draw_end) bad = {bad, " draw_end"};
            if (rsp_data.texture_index !== e.texture_index) bad = {bad, " texture_index"};
            if (rsp_data.wall_fraction !== e.wall_fraction) bad = {bad, " wall_fraction"};
            if (bad != "") begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch in%s: expected %h actual %h", bad, e, rsp_data);
            end
         end
      end
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Send one item; called and returning at a falling edge
   task automatic send_one(input req_type r, input bit fixed, input rsp_type want);
      int start;
      start = req_count;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      use_fixed = fixed;
      fixed_rsp = want;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (req_count == start);
   endtask

   // Write every not yet written cell that a cast would read before sending the cast
   task automatic send_item(input req_type r, input bit fixed, input rsp_type want);
      req_type fill;
      int      unk;
      if (r.operation == OP_CAST) begin
         void'(cast_column(r, unk));
         while (unk >= 0) begin
            fill = '0;
            fill.operation  = OP_MAP_WRITE;
            fill.column     = r.column;
            fill.cell_x     = 6'(unk / MAP_SIZE);
            fill.cell_y     = 6'(unk % MAP_SIZE);
            fill.cell_value = ($urandom_range(0, 4) == 0) ? WALL_CODE
                                                          : 8'($urandom_range(0, 255));
            send_one(fill, 1'b0, '0);
            void'(cast_column(r, unk));
         end
      end
      send_one(r, fixed, want);
   endtask

   // Hold off until the block is idle, then load all eight registers
   task automatic load_camera(input logic [21:0] px, input logic [21:0] py,
                              input logic [17:0] dx, input logic [17:0] dy,
                              input logic [17:0] plx, input logic [17:0] ply,
                              input logic [11:0] sw, input logic [11:0] sh);
      logic [21:0] vals [8];
      int          start;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      vals = '{px, py, 22'(dx), 22'(dy), 22'(plx), 22'(ply), 22'(sw), 22'(sh)};
      for (int i = 0; i < 8; i++) begin
         start = csr_count;
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         do @(negedge clock); while (csr_count == start);
      end
      csr_valid <= 1'b0;
      cam_pos_x = px;  cam_pos_y = py;
      cam_dir_x = dx;  cam_dir_y = dy;
      cam_plane_x = plx; cam_plane_y = ply;
      scr_width = sw;  scr_height = sh;
   endtask

   function automatic req_type random_item();
      req_type r;
      r.operation  = ($urandom_range(0, 1) == 0) ? OP_MAP_WRITE : OP_CAST;
      r.cell_x     = 6'($urandom_range(0, 63));
      r.cell_y     = 6'($urandom_range(0, 63));
      r.cell_value = ($urandom_range(0, 4) == 0) ? WALL_CODE : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0 || scr_width == 0) r.column = 11'($urandom_range(0, 2047));
      else r.column = 11'($urandom_range(0, scr_width - 1));
      return r;
   endfunction

   initial begin
      rsp_type none;
      int      phase_end;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      use_fixed = 1'b0;
      fixed_rsp = '0;
      cam_pos_x = '0; cam_pos_y = '0;
      cam_dir_x = 18'sd65536; cam_dir_y = '0;
      cam_plane_x = '0; cam_plane_y = 18'sd43254;
      scr_width = 12'd640; scr_height = 12'd480;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table under reset camera settings
      directed.push_back('{'{OP_MAP_WRITE, 11'd5, 6'd0, 6'd0, 8'd0}, 1'b1, written_rsp(11'd5)});
      directed.push_back('{'{OP_MAP_WRITE, 11'd2047, 6'd63, 6'd63, 8'd255}, 1'b1,
                           written_rsp(11'd2047)});
      directed.push_back('{'{OP_MAP_WRITE, 11'd0, 6'd40, 6'd0, 8'd49}, 1'b1, written_rsp(11'd0)});
      directed.push_back('{'{OP_CAST, 11'd0, 6'd0, 6'd0, 8'd0}, 1'b0, none});
      directed.push_back('{'{OP_CAST, 11'd320, 6'd63, 6'd63, 8'd255}, 1'b0, none});
      directed.push_back('{'{OP_CAST, 11'd639, 6'd0, 6'd0, 8'd0}, 1'b0, none});
      directed.push_back('{'{OP_CAST, 11'd2047, 6'd0, 6'd0, 8'd0}, 1'b0, none});
      directed.push_back('{'{OP_MAP_WRITE, 11'd1, 6'd1, 6'd0, 8'd49}, 1'b1, written_rsp(11'd1)});
      directed.push_back('{'{OP_CAST, 11'd320, 6'd0, 6'd0, 8'd0}, 1'b0, none});
      directed.push_back('{'{OP_MAP_WRITE, 11'd2, 6'd1, 6'd0, 8'd0}, 1'b1, written_rsp(11'd2)});
      directed.push_back('{'{OP_CAST, 11'd320, 6'd0, 6'd0, 8'd0}, 1'b0, none});
      foreach (directed[i]) send_item(directed[i].item, directed[i].fixed, directed[i].want);

      // Extreme camera settings: far corner, zero ray axis, zero and huge screens
      load_camera(22'h3FFFFF, 22'h3FFFFF, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000,
                  12'd0, 12'd0);
      for (int i = 0; i < 12; i++) send_item(random_item(), 1'b0, none);
      load_camera(22'h200000, 22'h208000, 18'h00000, 18'h10000, 18'h00000, 18'h00000,
                  12'd4095, 12'd4095);
      for (int i = 0; i < 12; i++) send_item(random_item(), 1'b0, none);
      load_camera(22'h218000, 22'h200000, 18'h10000, 18'h00000, 18'h00000, 18'h00000,
                  12'd1, 12'd1);
      for (int i = 0; i < 12; i++) send_item(random_item(), 1'b0, none);

      // Random phases; the last one runs without idling
      for (int ph = 0; ph < 8; ph++) begin
         load_camera(22'($urandom_range(0, 22'h3FFFFF)), 22'($urandom_range(0, 22'h3FFFFF)),
                     ($urandom_range(0, 5) == 0) ? 18'h0 : 18'($urandom),
                     ($urandom_range(0, 5) == 0) ? 18'h0 : 18'($urandom),
                     18'($urandom), 18'($urandom),
                     ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(1, 2048)),
                     ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(1, 2048)));
         quiet = (ph == 7);
         phase_end = req_count + 180;
         while (req_count < phase_end) send_item(random_item(), 1'b0, none);
      end
      req_valid <= 1'b0;

      // Drain, then allow for the block's tail
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
